FILE: hw/rtl/rlrs_pkg.sv
// ----------------------------------------------------------------------------
// rlrs_pkg
// Shared types and constants for the repeat limiter with random substitute.
// ----------------------------------------------------------------------------
package rlrs_pkg;

   localparam int unsigned VAL_W   = 16;            // input value width
   localparam int unsigned OUT_W   = 17;            // output value width
   localparam int unsigned LCG_W   = 32;            // generator state width
   localparam int unsigned DVD_W   = 17;            // remainder dividend width
   localparam int unsigned CNT_W   = 5;             // remainder step counter width
   localparam logic [CNT_W-1:0] REM_STEPS = 5'd17;  // one step per dividend bit

   localparam logic [LCG_W-1:0] LCG_MUL    = 32'd472940017;
   localparam logic [LCG_W-1:0] LCG_ADD    = 32'd832416023;
   localparam logic [LCG_W-1:0] SEED_RESET = 32'd1267631501;

   localparam logic [15:0] RANGE_RESET = 16'd3;
   localparam logic [15:0] LIMIT_RESET = 16'd2;

   // register indexes
   localparam logic [1:0] CSR_VALUE_RANGE  = 2'd0;
   localparam logic [1:0] CSR_REPEAT_LIMIT = 2'd1;
   localparam logic [1:0] CSR_SEED         = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LCG,
      ST_SCALE,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } state_type;

   // control decoded from the sequencer state
   typedef struct packed {
      logic req_ready;
      logic eval;
      logic lcg_step;
      logic scale;
      logic div_start;
      logic div_wait;
      logic finish;
   } ctrl_type;

endpackage

FILE: hw/rtl/rlrs_rem_unit.sv
// ----------------------------------------------------------------------------
// rlrs_rem_unit
// Bit-serial restoring remainder: one shift/compare/subtract per cycle.
// ----------------------------------------------------------------------------
module rlrs_rem_unit import rlrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [15:0]      divisor,
   output logic             done,
   output logic [15:0]      remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [15:0]      dvs_ff, dvs_in;
   logic [15:0]      rem_ff, rem_in;
   logic [16:0]      trial;
   logic [16:0]      diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = REM_STEPS;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         // trial below 2*divisor, so one subtract restores the bound
         rem_in = (trial >= {1'b0, dvs_ff}) ? diff[15:0] : trial[15:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("start did not launch the unit");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == 5'd1) |=> (done_ff && !busy_ff))
      else $error("last step did not raise done");

endmodule

FILE: hw/rtl/repeat_limiter_random_substitute.sv
// ----------------------------------------------------------------------------
// repeat_limiter_random_substitute
// Passes values through, replacing a value that repeats the previous output
// too often by a pseudo-random substitute from a 32-bit LCG.
// ----------------------------------------------------------------------------
// Sequence: a transaction is accepted in idle, evaluated, and loaded into the
//   output register in the done state, which waits for the output to be free;
//   a substitute runs LCG step, scale, sum and the serial remainder in between.
//   A new transaction is accepted only after the previous one leaves done.
// Reset: synchronous; registers return to range 3, limit 2, seed 1267631501,
//   previous output 0, repeat count 0. No clearing pass.
module repeat_limiter_random_substitute import rlrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_in_value,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_out_value,
   output logic                    rsp_was_replaced,
   output logic [LCG_W-1:0]        rsp_gen_state,
   // configuration
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   ctrl_type         ctrl;

   logic [15:0]      range_ff;      // value_range register
   logic [15:0]      limit_ff;      // repeat_limit register
   logic [LCG_W-1:0] lcg_ff;        // generator state
   logic [OUT_W-1:0] last_ff;       // previous output
   logic [15:0]      count_ff, count_in;

   // per-transaction working registers
   logic [VAL_W-1:0] din_ff;
   logic [15:0]      scaled_ff;
   logic             neg_ff;
   logic [OUT_W-1:0] res_ff, res_in;
   logic             repl_ff, repl_in;

   // output register
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_value_ff;
   logic             rsp_repl_ff;
   logic [LCG_W-1:0] rsp_state_ff;

   // ---------------------------------------------------------------------
   // effective configuration: zero range acts as 1, zero limit acts as 1,
   // scale factor m = max(range-1, 1)
   // ---------------------------------------------------------------------
   logic [15:0] n_eff;
   logic [15:0] lim_eff;
   logic [15:0] m_eff;

   assign n_eff   = (range_ff == 16'd0) ? 16'd1 : range_ff;
   assign lim_eff = (limit_ff == 16'd0) ? 16'd1 : limit_ff;
   assign m_eff   = (n_eff <= 16'd2) ? 16'd1 : (n_eff - 16'd1);

   // ---------------------------------------------------------------------
   // repeat detection
   // ---------------------------------------------------------------------
   logic [OUT_W-1:0] din_ext;
   logic             match;
   logic             replace;

   assign din_ext = {din_ff[VAL_W-1], din_ff};
   assign match   = (din_ext == last_ff);
   assign replace = match && (count_ff >= lim_eff);

   // ---------------------------------------------------------------------
   // shared multiplier: LCG step (low word) then m*state (bits 47:32)
   // ---------------------------------------------------------------------
   logic [LCG_W-1:0] mul_a;
   logic [63:0]      product;

   assign mul_a   = ctrl.lcg_step ? LCG_MUL : {16'd0, m_eff};
   assign product = 64'(mul_a) * 64'(lcg_ff);

   // ---------------------------------------------------------------------
   // sum = scaled + value + 1 as an 18-bit two's complement word, split
   // into sign and magnitude for the truncated remainder
   // ---------------------------------------------------------------------
   logic [17:0]      sum;
   logic [17:0]      sum_abs;
   logic [DVD_W-1:0] div_dvd;
   logic             div_done;
   logic [15:0]      div_rem;

   assign sum     = {2'b00, scaled_ff} + {{2{din_ff[VAL_W-1]}}, din_ff} + 18'd1;
   assign sum_abs = sum[17] ? (~sum + 18'd1) : sum;
   assign div_dvd = sum_abs[DVD_W-1:0];

   rlrs_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (div_dvd),
      .divisor   (n_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ---------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------
   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_EVAL;
         ST_EVAL:  state_in = replace ? ST_LCG : ST_DONE;
         ST_LCG:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer: decoded controls
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:  ctrl.req_ready = 1'b1;
         ST_EVAL:  ctrl.eval      = 1'b1;
         ST_LCG:   ctrl.lcg_step  = 1'b1;
         ST_SCALE: ctrl.scale     = 1'b1;
         ST_SUM:   ctrl.div_start = 1'b1;
         ST_DIV:   ctrl.div_wait  = 1'b1;
         ST_DONE:  ctrl.finish    = rsp_free;
         default:  ctrl = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // result and counter next values
   // ---------------------------------------------------------------------
   logic [OUT_W-1:0] rem_ext;
   assign rem_ext = {1'b0, div_rem};

   always_comb begin
      count_in = count_ff;
      res_in   = res_ff;
      repl_in  = repl_ff;
      if (ctrl.eval) begin
         res_in  = din_ext;
         repl_in = 1'b0;
         if (!match) begin
            count_in = 16'd1;
         end else if (replace) begin
            count_in = 16'd1;
         end else begin
            count_in = count_ff + 16'd1;
         end
      end else if (ctrl.div_wait && div_done) begin
         // remainder takes the sign of the dividend
         res_in  = neg_ff ? (~rem_ext + 17'd1) : rem_ext;
         repl_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= RANGE_RESET;
         limit_ff     <= LIMIT_RESET;
         lcg_ff       <= SEED_RESET;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;

         if (csr_write_en && csr_index == CSR_VALUE_RANGE) begin
            range_ff <= csr_wdata[15:0];
         end
         if (csr_write_en && csr_index == CSR_REPEAT_LIMIT) begin
            limit_ff <= csr_wdata[15:0];
         end

         // seed write loads the generator directly
         if (csr_write_en && csr_index == CSR_SEED) begin
            lcg_ff <= csr_wdata;
         end else if (ctrl.lcg_step) begin
            lcg_ff <= product[31:0] + LCG_ADD;
         end

         if (ctrl.finish) begin
            last_ff      <= res_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // payload, no reset
      if (req_valid && ctrl.req_ready) begin
         din_ff <= req_in_value;
      end
      if (ctrl.scale) begin
         scaled_ff <= product[47:32];
      end
      if (ctrl.div_start) begin
         neg_ff <= sum[17];
      end
      res_ff  <= res_in;
      repl_ff <= repl_in;
      if (ctrl.finish) begin
         rsp_value_ff <= res_ff;
         rsp_repl_ff  <= repl_ff;
         rsp_state_ff <= lcg_ff;
      end
   end

   assign req_ready        = ctrl.req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_was_replaced = rsp_repl_ff;
   assign rsp_gen_state    = rsp_state_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   logic [OUT_W-1:0] rsp_mag;
   assign rsp_mag = rsp_value_ff[OUT_W-1] ? (~rsp_value_ff + 17'd1) : rsp_value_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second transaction while busy");

   a_subst_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_repl_ff) |-> (rsp_mag < {1'b0, n_eff}))
      else $error("substitute outside the value range");

   a_lcg_step: assert property (@(posedge clock) disable iff (reset)
      (ctrl.lcg_step && !csr_write_en)
         |=> (lcg_ff == 32'($past(lcg_ff) * LCG_MUL + LCG_ADD)))
      else $error("generator step mismatch");

endmodule

FILE: tb/repeat_limiter_random_substitute_tb.sv
// ----------------------------------------------------------------------------
// repeat_limiter_random_substitute_tb
// Self-checking bench: a table of directed transactions, then randomized
// register settings with mostly repeating values. Responses are checked in
// order against typed table rows or an in-bench model of the limiter and LCG.
// ----------------------------------------------------------------------------
module repeat_limiter_random_substitute_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rlrs_pkg::*;

   // ------------------------------------------------------------------------
   // bench knobs
   // ------------------------------------------------------------------------
   localparam int SETTLE_CYCLES = 40;    // covers the longest substitute, plus margin
   localparam int RAND_PHASES   = 13;    // register settings in random part
   localparam int PHASE_ITEMS   = 50;    // transactions per setting
   localparam int MAX_SHOWN     = 10;    // mismatches printed in full
   localparam int HOLD_AT       = 230;   // response count that starts the hold
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int CALM_FIRST    = 300;   // no idling on either side between
   localparam int CALM_LAST     = 420;   //   these transaction counts

   localparam logic [1:0] CSR_UNUSED = 2'd3;   // no register here, write ignored

   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic                    replaced;
      logic [LCG_W-1:0]        gen;
   } rsp_type;

   localparam rsp_type NO_EXP = '0;

   typedef enum bit {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [1:0]              idx;
      logic [31:0]             data;
      logic signed [VAL_W-1:0] value;
      bit                      typed;   // exp below is authoritative
      rsp_type                 exp;
   } plan_row_type;

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_in_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out_value;
   logic                    rsp_was_replaced;
   logic [LCG_W-1:0]        rsp_gen_state;
   logic                    csr_write_en = 1'b0;
   logic [1:0]              csr_index = '0;
   logic [31:0]             csr_wdata = '0;

   repeat_limiter_random_substitute u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_value     (req_in_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_was_replaced (rsp_was_replaced),
      .rsp_gen_state    (rsp_gen_state),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // model state and scoreboard
   // ------------------------------------------------------------------------
   int unsigned      cfg_range = 32'(RANGE_RESET);
   int unsigned      cfg_limit = 32'(LIMIT_RESET);
   logic [LCG_W-1:0] lcg_q     = SEED_RESET;
   int               prev_out  = 0;
   int unsigned      rep_cnt   = 0;

   rsp_type pending_rsp [$];        // expected responses, oldest first

   int   fail_count   = 0;
   int   items_sent   = 0;
   int   rsp_seen     = 0;
   int   subs_seen    = 0;
   int   settings_cnt = 0;
   bit   calm         = 1'b0;       // suppress random idling on both sides
   bit   csr_active   = 1'b0;       // write enable left high by last write
   logic signed [VAL_W-1:0] last_in = '0;

   // Model of one transaction: pass through, or substitute once the
   // previous output has repeated repeat_limit times.
   function automatic rsp_type limit_and_substitute(input logic signed [VAL_W-1:0] v);
      int          d;
      int unsigned n;
      int unsigned lim;
      int unsigned m;
      logic [63:0] prod;
      longint      scaled;
      longint      sum;
      rsp_type     r;
      d = int'(v);
      n   = (cfg_range < 1) ? 1 : cfg_range;     // zero range acts as one
      lim = (cfg_limit < 1) ? 1 : cfg_limit;     // zero limit acts as one
      r.replaced = 1'b0;
      if (d == prev_out) begin
         if (rep_cnt >= lim) begin
            m = (n - 1 < 1) ? 1 : n - 1;         // scale never below one
            rep_cnt = 1;
            lcg_q  = lcg_q * LCG_MUL + LCG_ADD;
            prod   = 64'(m) * 64'(lcg_q);
            scaled = longint'(prod >> 32);
            sum    = scaled + d + 1;
            d      = int'(sum % longint'(n));    // truncated, sign of the sum
            r.replaced = 1'b1;
         end else begin
            rep_cnt++;                           // stays at or below the limit
         end
      end else begin
         rep_cnt = 1;
      end
      prev_out = d;
      r.value  = d[OUT_W-1:0];
      r.gen    = lcg_q;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // driver tasks
   // ------------------------------------------------------------------------

   // Drop valid, let everything drain, then give the block time to finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      settings_cnt++;
   endtask

   // Leaves the write enable high; the next transaction lowers it, so
   // back-to-back writes never toggle it within one step.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_VALUE_RANGE:  cfg_range = 32'(data[15:0]);
         CSR_REPEAT_LIMIT: cfg_limit = 32'(data[15:0]);
         CSR_SEED:         lcg_q     = data;
         default: ;
      endcase
      csr_active = 1'b1;
   endtask

   task automatic send_item(input logic signed [VAL_W-1:0] v, input bit typed,
                            input rsp_type typed_exp);
      int      gap;
      rsp_type pred;
      gap = 0;
      if (csr_active) begin
         csr_write_en <= 1'b0;
         csr_active = 1'b0;
      end
      while (!calm && $urandom_range(0, 99) < 33) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge; the model advances in acceptance order
      pred = limit_and_substitute(v);
      pending_rsp.push_back(typed ? typed_exp : pred);
      last_in = v;
      items_sent++;
   endtask

   // Mostly repeat the previous output so the counter climbs to the limit,
   // with some repeats of the last input, corner values and noise.
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] corner_vals [5];
      int                      r;
      corner_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
      r = $urandom_range(0, 99);
      if (r < 50 && prev_out >= -32768 && prev_out <= 32767)
         return prev_out[VAL_W-1:0];
      if (r < 70) return last_in;
      if (r < 80) return corner_vals[$urandom_range(0, 4)];
      return 16'($urandom);
   endfunction

   task automatic random_settings();
      logic [15:0] rng;
      logic [15:0] lim;
      logic [31:0] sd;
      settle();
      case ($urandom_range(0, 7))
         0:       rng = 16'd0;
         1:       rng = 16'd1;
         2:       rng = 16'd2;
         3:       rng = 16'hFFFF;
         4, 5:    rng = 16'($urandom_range(3, 16));
         default: rng = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       lim = 16'd0;
         1:       lim = 16'd1;
         2, 3:    lim = 16'd2;
         4:       lim = 16'hFFFF;
         5:       lim = 16'($urandom);
         default: lim = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
         0:       sd = 32'd0;
         1:       sd = 32'hFFFF_FFFF;
         default: sd = $urandom;
      endcase
      // upper data bits are random; only the low half may land
      csr_write(CSR_VALUE_RANGE, {16'($urandom), rng});
      csr_write(CSR_REPEAT_LIMIT, {16'($urandom), lim});
      // sometimes skip the seed so the generator runs on across settings
      if ($urandom_range(0, 9) < 7) csr_write(CSR_SEED, sd);
      if ($urandom_range(0, 9) == 0) csr_write(CSR_UNUSED, $urandom);
   endtask

   // ------------------------------------------------------------------------
   // directed table
   // Typed rows: pass-throughs right after reset or a seed write, and the
   // range-of-one substitute right after seed 0 (state becomes the addend).
   // ------------------------------------------------------------------------
   localparam int N_ROWS = 41;

   plan_row_type plan [N_ROWS] = '{
      // reset settings: range 3, limit 2; third zero is substituted
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0000, 1'b1, '{17'sh00000, 1'b0, SEED_RESET}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0000, 1'b1, '{17'sh00000, 1'b0, SEED_RESET}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      // negative repeats: substitute keeps the sign of the sum
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh8000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh8000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh8000, 1'b0, NO_EXP},
      // zero range and zero limit, seed 0
      '{ROW_CSR, CSR_VALUE_RANGE,  32'd0, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_REPEAT_LIMIT, 32'd0, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_SEED,         32'd0, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0007, 1'b1, '{17'sh00007, 1'b0, 32'd0}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0007, 1'b1, '{17'sh00000, 1'b1, LCG_ADD}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0000, 1'b0, NO_EXP},
      // all-ones data: range and limit at their top, seed all ones
      '{ROW_CSR, CSR_VALUE_RANGE,  32'hFFFF_FFFF, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_REPEAT_LIMIT, 32'h0000_FFFF, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_SEED,         32'hFFFF_FFFF, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh8000, 1'b1, '{17'sh18000, 1'b0, 32'hFFFF_FFFF}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b1, '{17'sh07FFF, 1'b0, 32'hFFFF_FFFF}},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      // range of two, limit one: every repeat of -1 is replaced
      '{ROW_CSR, CSR_VALUE_RANGE,  32'd2,     16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_REPEAT_LIMIT, 32'd1,     16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_SEED,         32'd12345, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'shFFFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'shFFFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'shFFFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'shFFFF, 1'b0, NO_EXP},
      // range one, limit three; the write to the empty index must not land
      '{ROW_CSR, CSR_VALUE_RANGE,  32'd1,         16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_REPEAT_LIMIT, 32'd3,         16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_UNUSED,       32'hFFFF_FFFF, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0064, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0064, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0064, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh0064, 1'b0, NO_EXP},
      // widest range with limit one, seed with only the top bit
      '{ROW_CSR, CSR_VALUE_RANGE,  32'h0000_FFFF, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_REPEAT_LIMIT, 32'd1,         16'sh0000, 1'b0, NO_EXP},
      '{ROW_CSR, CSR_SEED,         32'h8000_0000, 16'sh0000, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh7FFF, 1'b0, NO_EXP},
      '{ROW_ITEM, CSR_UNUSED, 32'd0, 16'sh8000, 1'b0, NO_EXP}
   };

   // ------------------------------------------------------------------------
   // stimulus: reset, directed table, random phases, drain, verdict
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!csr_active) settle();   // first write of a group waits for idle
            csr_write(plan[i].idx, plan[i].data);
         end else begin
            send_item(plan[i].value, plan[i].typed, plan[i].exp);
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         random_settings();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
            send_item(pick_value(), 1'b0, NO_EXP);
         end
      end
      calm = 1'b0;

      // drain, then watch for stray responses
      req_valid <= 1'b0;
      if (csr_active) csr_write_en <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d transactions, %0d substituted, across %0d register settings",
               rsp_seen, subs_seen, settings_cnt);
      $display("Mismatches: %0d", fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver: random ready, one long hold-off, in-order checking
   // ------------------------------------------------------------------------
   initial begin
      int      hold_left;
      bit      hold_done;
      rsp_type got;
      rsp_type exp;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_out_value, rsp_was_replaced, rsp_gen_state};
            rsp_seen++;
            if (got.replaced === 1'b1) subs_seen++;
            if (pending_rsp.size() == 0) begin
               note_failure($sformatf("unexpected transaction: value %0d repl %0b gen %h",
                                      got.value, got.replaced, got.gen));
            end else begin
               exp = pending_rsp.pop_front();
               if (got.value !== exp.value || got.replaced !== exp.replaced ||
                   got.gen !== exp.gen)
                  note_failure($sformatf(
                     "mismatch #%0d: exp value %0d repl %0b gen %h, got %0d %0b %h",
                     rsp_seen, exp.value, exp.replaced, exp.gen,
                     got.value, got.replaced, got.gen));
            end
         end
         // long stall: sender keeps offering, the block backs up
         if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   // watchdog: fails the run if it does not finish in time
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
